// ===== hw/rtl/aabbat_pkg.sv =====
// Shared widths, types and register indexes of the box transform pipeline.
// Used by every module of the block; depends on nothing.
package aabbat_pkg;

  localparam int COORD_W    = 24;
  localparam int ROT_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_SHIFT = 23;
  localparam int COORD_MAX  = 8388607;
  localparam int COORD_MIN  = -8388608;

  localparam int HALF_W = COORD_W + 1;
  localparam int SC_W   = HALF_W + SCALE_W + 1;
  localparam int PROD_W = SC_W + ROT_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SUM_W  = ACC_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [HALF_W-1:0]  half_t;
  typedef logic signed [SC_W-1:0]    sc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam sum_t ROUND_BIAS = sum_t'(1) <<< (FRAC_SHIFT - 1);

  typedef struct packed {
    logic [2:0][CFG_DATA_W-1:0] rot_row;
    logic [2:0][COORD_W-1:0]    trans;
    logic [SCALE_W-1:0]         scale;
  } cfg_t;

endpackage

// ===== hw/rtl/aabbat_prep.sv =====
// Stages one and two: doubled center and extent, then multiplication by the scale.
// Depends on aabbat_pkg.
module aabbat_prep (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  aabbat_pkg::cfg_t        cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  aabbat_pkg::coord_t      lo_i [3],
  input  aabbat_pkg::coord_t      hi_i [3],
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output aabbat_pkg::sc_t         sc_o [3],
  output aabbat_pkg::sc_t         se_o [3]
);

  logic v1_q, v2_q;
  logic en1, en2;
  aabbat_pkg::half_t c2_q [3];
  aabbat_pkg::half_t e2_q [3];
  aabbat_pkg::sc_t   sc_q [3];
  aabbat_pkg::sc_t   se_q [3];
  aabbat_pkg::sc_t   s_ext;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign s_ext      = aabbat_pkg::sc_t'({1'b0, cfg_i.scale});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en1) begin
        c2_q[i] <= aabbat_pkg::half_t'(hi_i[i]) + aabbat_pkg::half_t'(lo_i[i]);
        e2_q[i] <= aabbat_pkg::half_t'(hi_i[i]) - aabbat_pkg::half_t'(lo_i[i]);
      end
      if (en2) begin
        sc_q[i] <= aabbat_pkg::sc_t'(c2_q[i]) * s_ext;
        se_q[i] <= aabbat_pkg::sc_t'(e2_q[i]) * s_ext;
      end
    end
  end

  assign out_valid_o = v2_q;
  assign sc_o        = sc_q;
  assign se_o        = se_q;

endmodule

// ===== hw/rtl/aabbat_rotate.sv =====
// Stages three and four: rotation and absolute rotation products, then row sums
// with the translation. Depends on aabbat_pkg.
module aabbat_rotate (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  aabbat_pkg::cfg_t        cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  aabbat_pkg::sc_t         sc_i [3],
  input  aabbat_pkg::sc_t         se_i [3],
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output aabbat_pkg::acc_t        acc_c_o [3],
  output aabbat_pkg::acc_t        acc_e_o [3]
);

  logic v3_q, v4_q;
  logic en3, en4;
  logic signed [aabbat_pkg::ROT_W-1:0] rot  [3][3];
  logic signed [aabbat_pkg::ROT_W:0]   rabs [3][3];
  aabbat_pkg::prod_t pc_q [3][3];
  aabbat_pkg::prod_t pe_q [3][3];
  aabbat_pkg::acc_t  acc_c_q [3];
  aabbat_pkg::acc_t  acc_e_q [3];

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign in_ready_o = en3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot[i][j]  = cfg_i.rot_row[i][j*aabbat_pkg::ROT_W +: aabbat_pkg::ROT_W];
        rabs[i][j] = rot[i][j][aabbat_pkg::ROT_W-1] ?
                     -(aabbat_pkg::ROT_W+1)'(rot[i][j]) : (aabbat_pkg::ROT_W+1)'(rot[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= in_valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en3) begin
        for (int j = 0; j < 3; j++) begin
          pc_q[i][j] <= aabbat_pkg::prod_t'(rot[i][j]) * aabbat_pkg::prod_t'(sc_i[j]);
          pe_q[i][j] <= aabbat_pkg::prod_t'(rabs[i][j]) * aabbat_pkg::prod_t'(se_i[j]);
        end
      end
      if (en4) begin
        acc_c_q[i] <= (aabbat_pkg::acc_t'($signed(cfg_i.trans[i])) <<< aabbat_pkg::FRAC_SHIFT)
                      + aabbat_pkg::acc_t'(pc_q[i][0]) + aabbat_pkg::acc_t'(pc_q[i][1])
                      + aabbat_pkg::acc_t'(pc_q[i][2]);
        acc_e_q[i] <= aabbat_pkg::acc_t'(pe_q[i][0]) + aabbat_pkg::acc_t'(pe_q[i][1])
                      + aabbat_pkg::acc_t'(pe_q[i][2]);
      end
    end
  end

  assign out_valid_o = v4_q;
  assign acc_c_o     = acc_c_q;
  assign acc_e_o     = acc_e_q;

endmodule

// ===== hw/rtl/aabbat_finish.sv =====
// Stages five and six: corner sums with rounding bias, then rounding shift,
// the extra LSB on the maximum corner and saturation. Depends on aabbat_pkg.
module aabbat_finish (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  aabbat_pkg::acc_t        acc_c_i [3],
  input  aabbat_pkg::acc_t        acc_e_i [3],
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output aabbat_pkg::coord_t      lo_o [3],
  output aabbat_pkg::coord_t      hi_o [3]
);

  logic v5_q, v6_q;
  logic en5, en6;
  aabbat_pkg::sum_t   lo_sum_q [3];
  aabbat_pkg::sum_t   hi_sum_q [3];
  aabbat_pkg::coord_t lo_q [3];
  aabbat_pkg::coord_t hi_q [3];

  function automatic aabbat_pkg::coord_t sat_coord(aabbat_pkg::sum_t v);
    aabbat_pkg::coord_t r;
    if (v > aabbat_pkg::sum_t'(aabbat_pkg::COORD_MAX)) begin
      r = aabbat_pkg::coord_t'(aabbat_pkg::COORD_MAX);
    end else if (v < aabbat_pkg::sum_t'(aabbat_pkg::COORD_MIN)) begin
      r = aabbat_pkg::coord_t'(aabbat_pkg::COORD_MIN);
    end else begin
      r = v[aabbat_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  assign en6        = !v6_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign in_ready_o = en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) begin
        v5_q <= in_valid_i;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en5) begin
        lo_sum_q[i] <= aabbat_pkg::sum_t'(acc_c_i[i]) - aabbat_pkg::sum_t'(acc_e_i[i])
                       + aabbat_pkg::ROUND_BIAS;
        hi_sum_q[i] <= aabbat_pkg::sum_t'(acc_c_i[i]) + aabbat_pkg::sum_t'(acc_e_i[i])
                       + aabbat_pkg::ROUND_BIAS;
      end
      if (en6) begin
        lo_q[i] <= sat_coord(lo_sum_q[i] >>> aabbat_pkg::FRAC_SHIFT);
        hi_q[i] <= sat_coord((hi_sum_q[i] >>> aabbat_pkg::FRAC_SHIFT) + aabbat_pkg::sum_t'(1));
      end
    end
  end

  assign out_valid_o = v6_q;
  assign lo_o        = lo_q;
  assign hi_o        = hi_q;

endmodule

// ===== hw/rtl/aabb_affine_transform.sv =====
// Throughput: one box per cycle while the output is not stalled; six register
// stages (add, scale multiply, rotation multiply, row sum, corner sum, round and
// saturate) each pass on one word. Reset clears all stage valid bits and loads
// the identity rotation, zero translation and unit scale. Depends on aabbat_pkg
// and the three stage modules.
module aabb_affine_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aabbat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aabbat_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: lo_x, lo_y, lo_z, hi_x, hi_y, hi_z.
  input  logic [6*aabbat_pkg::COORD_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z.
  output logic [6*aabbat_pkg::COORD_W-1:0]  m_axis_tdata
);

  localparam int CW = aabbat_pkg::COORD_W;

  logic [aabbat_pkg::CFG_DATA_W-1:0] rot_row_q [3];
  logic [CW-1:0]                     trans_q [3];
  logic [aabbat_pkg::SCALE_W-1:0]    scale_q;
  aabbat_pkg::cfg_t                  cfg;

  aabbat_pkg::coord_t in_lo [3];
  aabbat_pkg::coord_t in_hi [3];
  aabbat_pkg::coord_t out_lo [3];
  aabbat_pkg::coord_t out_hi [3];
  aabbat_pkg::sc_t    sc [3];
  aabbat_pkg::sc_t    se [3];
  aabbat_pkg::acc_t   acc_c [3];
  aabbat_pkg::acc_t   acc_e [3];

  logic prep_valid, rot_ready;
  logic rot_valid, fin_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row_q[0] <= aabbat_pkg::CFG_DATA_W'(64'd16384);
      rot_row_q[1] <= aabbat_pkg::CFG_DATA_W'(64'd16384 << 16);
      rot_row_q[2] <= aabbat_pkg::CFG_DATA_W'(64'd16384 << 32);
      trans_q[0]   <= '0;
      trans_q[1]   <= '0;
      trans_q[2]   <= '0;
      scale_q      <= aabbat_pkg::SCALE_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aabbat_pkg::REG_ROT_ROW_0:   rot_row_q[0] <= cfg_wdata_i;
        aabbat_pkg::REG_ROT_ROW_1:   rot_row_q[1] <= cfg_wdata_i;
        aabbat_pkg::REG_ROT_ROW_2:   rot_row_q[2] <= cfg_wdata_i;
        aabbat_pkg::REG_TRANSLATE_X: trans_q[0]   <= cfg_wdata_i[CW-1:0];
        aabbat_pkg::REG_TRANSLATE_Y: trans_q[1]   <= cfg_wdata_i[CW-1:0];
        aabbat_pkg::REG_TRANSLATE_Z: trans_q[2]   <= cfg_wdata_i[CW-1:0];
        aabbat_pkg::REG_SCALE:       scale_q      <= cfg_wdata_i[aabbat_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg.rot_row[i] = rot_row_q[i];
      cfg.trans[i]   = trans_q[i];
      in_lo[i]       = s_axis_tdata[i*CW +: CW];
      in_hi[i]       = s_axis_tdata[(i+3)*CW +: CW];
      m_axis_tdata[i*CW +: CW]     = out_lo[i];
      m_axis_tdata[(i+3)*CW +: CW] = out_hi[i];
    end
    cfg.scale = scale_q;
  end

  aabbat_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .lo_i        (in_lo),
    .hi_i        (in_hi),
    .out_valid_o (prep_valid),
    .out_ready_i (rot_ready),
    .sc_o        (sc),
    .se_o        (se)
  );

  aabbat_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (prep_valid),
    .in_ready_o  (rot_ready),
    .sc_i        (sc),
    .se_i        (se),
    .out_valid_o (rot_valid),
    .out_ready_i (fin_ready),
    .acc_c_o     (acc_c),
    .acc_e_o     (acc_e)
  );

  aabbat_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (fin_ready),
    .acc_c_i     (acc_c),
    .acc_e_i     (acc_e),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .lo_o        (out_lo),
    .hi_o        (out_hi)
  );

endmodule

// ===== sim/aabb_transform_checker.sv =====
// Checker for the box transform block: tracks the transform registers through the
// write port, predicts the bounding box of every accepted input word and compares the
// output words in order. Depends on aabbat_pkg.
`timescale 1ns / 100ps

module aabb_transform_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aabbat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aabbat_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [6*aabbat_pkg::COORD_W-1:0]  s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [6*aabbat_pkg::COORD_W-1:0]  m_axis_tdata,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);
  import aabbat_pkg::*;

  localparam int WORD_W = 6 * COORD_W;

  cfg_t              xform;
  logic [WORD_W-1:0] bounds_q[$];
  string             field_names[6] = '{"out_lo_x", "out_lo_y", "out_lo_z",
                                        "out_hi_x", "out_hi_y", "out_hi_z"};

  function automatic coord_t to_coord(input longint acc, input longint extra);
    longint q;
    q = ((acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT) + extra;
    if (q > COORD_MAX) q = COORD_MAX;
    else if (q < COORD_MIN) q = COORD_MIN;
    return coord_t'(q);
  endfunction

  function automatic logic [WORD_W-1:0] transformed_bounds(input logic [WORD_W-1:0] box,
                                                           input cfg_t xf);
    longint            twice_c[3];
    longint            twice_e[3];
    longint            lo, hi, ent, scale, acc_c, acc_e;
    logic [WORD_W-1:0] bounds;
    scale = longint'(xf.scale);
    for (int a = 0; a < 3; a++) begin
      lo = longint'($signed(box[a*COORD_W +: COORD_W]));
      hi = longint'($signed(box[(a+3)*COORD_W +: COORD_W]));
      twice_c[a] = lo + hi;
      twice_e[a] = hi - lo;
    end
    for (int r = 0; r < 3; r++) begin
      acc_c = longint'($signed(xf.trans[r])) <<< FRAC_SHIFT;
      acc_e = 0;
      for (int k = 0; k < 3; k++) begin
        ent = longint'($signed(xf.rot_row[r][k*ROT_W +: ROT_W]));
        acc_c += ent * scale * twice_c[k];
        acc_e += (ent < 0 ? -ent : ent) * scale * twice_e[k];
      end
      bounds[r*COORD_W +: COORD_W]     = to_coord(acc_c - acc_e, 0);
      bounds[(r+3)*COORD_W +: COORD_W] = to_coord(acc_c + acc_e, 1);
    end
    return bounds;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WORD_W-1:0] want;
    coord_t            want_f, got_f;
    if (!rst_ni) begin
      xform.rot_row[0] = 48'd16384;
      xform.rot_row[1] = 48'd16384 << 16;
      xform.rot_row[2] = 48'd16384 << 32;
      xform.trans      = '0;
      xform.scale      = 16'd256;
      bounds_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (bounds_q.size() == 0) begin
          fail_count_o++;
          $error("output word %h arrived with no box pending", m_axis_tdata);
        end else begin
          want = bounds_q.pop_front();
          for (int f = 0; f < 6; f++) begin
            want_f = want[f*COORD_W +: COORD_W];
            got_f  = m_axis_tdata[f*COORD_W +: COORD_W];
            if (got_f !== want_f) begin
              fail_count_o++;
              $error("%s: expected %0d, got %0d", field_names[f], want_f, got_f);
            end
          end
          checked_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        bounds_q.push_back(transformed_bounds(s_axis_tdata, xform));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROT_ROW_0:   xform.rot_row[0] = cfg_wdata_i;
          REG_ROT_ROW_1:   xform.rot_row[1] = cfg_wdata_i;
          REG_ROT_ROW_2:   xform.rot_row[2] = cfg_wdata_i;
          REG_TRANSLATE_X: xform.trans[0]   = cfg_wdata_i[COORD_W-1:0];
          REG_TRANSLATE_Y: xform.trans[1]   = cfg_wdata_i[COORD_W-1:0];
          REG_TRANSLATE_Z: xform.trans[2]   = cfg_wdata_i[COORD_W-1:0];
          REG_SCALE:       xform.scale      = cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = bounds_q.size();
  end

endmodule

// ===== sim/aabb_affine_transform_tb.sv =====
// Top of the box transform testbench: clock, reset, transform settings and box stimulus
// with random gaps and stalls on both sides. Depends on aabbat_pkg, the block and
// the checker in aabb_transform_checker.sv.
`timescale 1ns / 100ps

module aabb_affine_transform_tb;
  import aabbat_pkg::*;

  localparam int WORD_W        = 6 * COORD_W;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_CYCLES  = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BOXES   = 108;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [ROT_W-1:0] ROT_ZERO      = 16'h0000;
  localparam logic [ROT_W-1:0] ROT_ONE       = 16'h4000;
  localparam logic [ROT_W-1:0] ROT_MINUS_ONE = 16'hC000;
  localparam logic [ROT_W-1:0] ROT_MAX       = 16'h7FFF;
  localparam logic [ROT_W-1:0] ROT_MIN       = 16'h8000;

  localparam coord_t C_MAX  = coord_t'(COORD_MAX);
  localparam coord_t C_MIN  = coord_t'(COORD_MIN);
  localparam coord_t C_ZERO = coord_t'(0);
  localparam coord_t C_ONE  = coord_t'(1);
  localparam coord_t C_NEG  = coord_t'(-1);

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [WORD_W-1:0]     s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [WORD_W-1:0]     m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int cycle_count   = 0;
  int boxes_sent    = 0;
  int settings_used = 0;
  int stall_left    = 0;
  bit stall_request = 1'b0;
  bit stall_taken   = 1'b0;
  bit steady        = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  aabb_affine_transform uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  aabb_transform_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_request && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left  = STALL_CYCLES;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  function automatic coord_t rand_coord(input int bits);
    int v;
    v = $urandom;
    v = v >>> (32 - bits);
    return coord_t'(v);
  endfunction

  function automatic logic [WORD_W-1:0] make_box(input coord_t lo, input coord_t hi);
    return {hi, hi, hi, lo, lo, lo};
  endfunction

  function automatic logic [WORD_W-1:0] random_box();
    logic [WORD_W-1:0] w;
    coord_t            a, b;
    int                kind, bits;
    kind = $urandom_range(0, 99);
    for (int ax = 0; ax < 3; ax++) begin
      bits = $urandom_range(4, COORD_W);
      a = (kind < 85 && kind >= 65) ? coord_t'($urandom) : rand_coord(bits);
      b = (kind < 85 && kind >= 65) ? coord_t'($urandom) : rand_coord(bits);
      if ((kind < 65) == (a > b)) begin
        w[ax*COORD_W +: COORD_W]     = b;
        w[(ax+3)*COORD_W +: COORD_W] = a;
      end else begin
        w[ax*COORD_W +: COORD_W]     = a;
        w[(ax+3)*COORD_W +: COORD_W] = b;
      end
    end
    return w;
  endfunction

  function automatic logic [ROT_W-1:0] random_entry();
    case ($urandom_range(0, 3))
      0: return ROT_ZERO;
      1: return ROT_ONE;
      2: return ROT_MINUS_ONE;
      default: return ROT_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_row();
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'({$urandom, $urandom});
    return {random_entry(), random_entry(), random_entry()};
  endfunction

  function automatic coord_t random_shift();
    return $urandom_range(0, 1) ? coord_t'($urandom) : rand_coord(14);
  endfunction

  task automatic send_box(input logic [WORD_W-1:0] word);
    while (!steady && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    boxes_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
  endtask

  task automatic load_xform(input logic [CFG_DATA_W-1:0] r0, input logic [CFG_DATA_W-1:0] r1,
                            input logic [CFG_DATA_W-1:0] r2, input coord_t tx,
                            input coord_t ty, input coord_t tz, input logic [SCALE_W-1:0] sc);
    put_reg(REG_ROT_ROW_0, r0);
    put_reg(REG_ROT_ROW_1, r1);
    put_reg(REG_ROT_ROW_2, r2);
    put_reg(REG_TRANSLATE_X, CFG_DATA_W'({$urandom, tx}));
    put_reg(REG_TRANSLATE_Y, CFG_DATA_W'({$urandom, ty}));
    put_reg(REG_TRANSLATE_Z, CFG_DATA_W'({$urandom, tz}));
    put_reg(REG_SCALE, CFG_DATA_W'({$urandom, $urandom, sc}));
    put_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  initial begin
    logic [SCALE_W-1:0] sc;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_box(make_box(C_ZERO, C_ZERO));
    send_box(make_box(C_MAX, C_MAX));
    send_box(make_box(C_MIN, C_MIN));
    send_box(make_box(C_MIN, C_MAX));
    send_box(make_box(C_MAX, C_MIN));
    send_box(make_box(C_ZERO, C_ONE));
    send_box(make_box(C_NEG, C_ZERO));
    send_box(random_box());
    settle();

    load_xform({ROT_MIN, ROT_MIN, ROT_MIN}, {ROT_MIN, ROT_MIN, ROT_MIN},
               {ROT_MIN, ROT_MIN, ROT_MIN}, C_MAX, C_MAX, C_MAX, 16'hFFFF);
    send_box(make_box(C_MAX, C_MAX));
    send_box(make_box(C_MIN, C_MIN));
    send_box(make_box(C_MAX, C_MIN));
    send_box(make_box(C_ZERO, C_ZERO));
    send_box(make_box(C_NEG, C_ONE));
    settle();

    load_xform({ROT_MAX, ROT_MIN, ROT_ZERO}, {ROT_MAX, ROT_MAX, ROT_MAX},
               {ROT_ZERO, ROT_MIN, ROT_MAX}, C_MIN, C_MIN, C_MIN, 16'h0000);
    send_box(make_box(C_MIN, C_MAX));
    send_box(make_box(C_MAX, C_MIN));
    send_box(random_box());
    settle();

    load_xform({ROT_ZERO, ROT_ONE, ROT_ZERO}, {ROT_MINUS_ONE, ROT_ZERO, ROT_ZERO},
               {ROT_ZERO, ROT_ZERO, ROT_ONE}, coord_t'(3), coord_t'(-5), C_ZERO, 16'h0080);
    send_box(make_box(C_ZERO, C_ONE));
    send_box(make_box(C_NEG, C_ZERO));
    send_box(make_box(coord_t'(-3), coord_t'(2)));
    send_box(make_box(C_MIN, C_MAX));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sc = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom) : SCALE_W'($urandom_range(32, 1024));
      load_xform(random_row(), random_row(), random_row(),
                 random_shift(), random_shift(), random_shift(), sc);
      steady = (p == 2);
      for (int n = 0; n < PHASE_BOXES; n++) begin
        if (p == 1 && n == 20) stall_request = 1'b1;
        if (p == 3 && n == PHASE_BOXES / 2) settle();
        send_box(random_box());
      end
      steady = 1'b0;
      settle();
    end

    $display("Checked %0d output words for %0d boxes under %0d transform settings,",
             checked, boxes_sent, settings_used);
    $display("with saturation, rounding ties, inverted boxes and a %0d-cycle output stall.",
             STALL_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/aabbat_pkg.sv
hw/rtl/aabbat_prep.sv
hw/rtl/aabbat_rotate.sv
hw/rtl/aabbat_finish.sv
hw/rtl/aabb_affine_transform.sv
sim/aabb_transform_checker.sv
sim/aabb_affine_transform_tb.sv
